[design/pmu_pkg.sv]
// pmu_pkg: types and constants of the polygon measures unit.
// Item formats, datapath widths, step counts, register indexes and state codes.
// No dependencies.
package pmu_pkg;

	localparam int COORD_W      = 16;
	localparam int FRAC_BITS    = 8;
	localparam int MAX_VERTICES = 4096;
	localparam int COUNT_W      = 13;
	localparam int AREA_W       = 48;
	localparam int TWICE_W      = 34;
	localparam int LEN_W        = 37;
	localparam int SUM_W        = 29;
	localparam int D2_W         = 2 * COORD_W + 2;
	localparam int ROOT_W       = D2_W / 2 + FRAC_BITS;
	localparam int SQRT_STEPS   = ROOT_W;
	localparam int DIV_STEPS    = SUM_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [0:0] REG_OPEN_MODE = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [TWICE_W-1:0]        twice_area;
		logic [LEN_W-1:0]          path_length_q8;
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic [COUNT_W-1:0]        point_count;
		logic                      overflow;
	} result_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL   = 9'b000000010,
		ST_PREP  = 9'b000000100,
		ST_ROOT  = 9'b000001000,
		ST_ACC   = 9'b000010000,
		ST_CLOSE = 9'b000100000,
		ST_DLOAD = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

endpackage

[design/pmu_stream_if.sv]
// pmu_stream_if: valid/ready channel carrying one item of type item_t.
// Used by the polygon measures unit for its vertex and result channels.
// No dependencies.
interface pmu_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[design/polygon_measures_unit.sv]
// polygon_measures_unit: streaming shoelace area, path length, box and centroid.
// Depends on pmu_pkg and pmu_stream_if.
//
//   channel   dir  handshake          item
//   vertex    in   valid/ready        vertex_x, vertex_y, last_vertex
//   result    out  valid/ready        twice area, length, box, centroid, count, overflow
//   apb       in   psel/penable       open_path_mode at word 0
//
// First vertex of a polygon, or one beyond capacity: taken in idle with no edge work.
// Any other vertex: product, prepare, 25-step bit-serial edge square root, accumulate.
// Last vertex adds a close state, the closing edge from 3 vertices up, a division load,
// the bit-serial centroid division and the load of the output register.
// Vertices are taken while a result waits; a new result waits for the old one to leave.
// Reset clears all accumulators and sets closed perimeter mode.
module polygon_measures_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	pmu_stream_if.sink                    vertex,
	pmu_stream_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmu_pkg::PADDR_W-1:0]   paddr,
	input  logic [pmu_pkg::PDATA_W-1:0]   pwdata,
	output logic [pmu_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import pmu_pkg::*;

	state_t state_q;
	logic   open_mode_q;

	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [AREA_W-1:0]         area_q;
	logic [LEN_W-1:0]          len_q;
	logic signed [SUM_W-1:0]   sum_x_q, sum_y_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      ovf_q;
	logic                      last_q;
	logic                      close_q;

	logic [D2_W-1:0]             sq_x_s1, sq_y_s1;
	logic signed [2*COORD_W-1:0] pa_s1, pb_s1;

	logic [D2_W-1:0]     d2_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [STEP_W-1:0]   step_q;

	logic [SUM_W-1:0]    dq_x_q, dq_y_q;
	logic [COUNT_W-1:0]  drem_x_q, drem_y_q;
	logic                neg_x_q, neg_y_q;

	logic                out_valid_q;
	result_t             out_q;

	// combinational helpers
	logic signed [COORD_W:0]       dx, dy;
	logic signed [D2_W-1:0]        sq_x, sq_y;
	logic signed [2*COORD_W:0]     term;
	logic [AREA_W-1:0]             term_ext;
	logic [ROOT_W+3:0]             rem_sh, trial;
	logic                          root_ge;
	logic [LEN_W:0]                len_sum;
	logic [LEN_W-1:0]              len_sat;
	logic [COUNT_W:0]              dsh_x, dsh_y;
	logic                          dge_x, dge_y;
	logic [AREA_W-1:0]             area_abs;
	logic [TWICE_W-1:0]            twice_sat;
	logic [SUM_W-1:0]              quo_x, quo_y;
	logic                          full, accept, emit_go;
	logic                          cfg_wr;
	logic signed [COORD_W-1:0]     vx, vy;

	assign vx     = vertex.payload.vertex_x;
	assign vy     = vertex.payload.vertex_y;
	assign full   = (count_q >= COUNT_W'(MAX_VERTICES));
	assign accept = vertex.valid && vertex.ready;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	assign vertex.ready   = (state_q == ST_IDLE);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_OPEN_MODE);
	assign prdata = (psel && (paddr[PADDR_W-1] == REG_OPEN_MODE)) ?
		{{(PDATA_W-1){1'b0}}, open_mode_q} : '0;

	always_comb begin
		dx       = {a_x_q[COORD_W-1], a_x_q} - {b_x_q[COORD_W-1], b_x_q};
		dy       = {a_y_q[COORD_W-1], a_y_q} - {b_y_q[COORD_W-1], b_y_q};
		sq_x     = dx * dx;
		sq_y     = dy * dy;
		term     = {pa_s1[2*COORD_W-1], pa_s1} - {pb_s1[2*COORD_W-1], pb_s1};
		term_ext = {{(AREA_W-2*COORD_W-1){term[2*COORD_W]}}, term};

		rem_sh  = {rem_q, d2_q[D2_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		root_ge = (rem_sh >= trial);

		len_sum = {1'b0, len_q} + (LEN_W+1)'(root_q);
		len_sat = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];

		dsh_x = {drem_x_q, dq_x_q[SUM_W-1]};
		dsh_y = {drem_y_q, dq_y_q[SUM_W-1]};
		dge_x = (dsh_x >= {1'b0, count_q});
		dge_y = (dsh_y >= {1'b0, count_q});

		area_abs  = area_q[AREA_W-1] ? (~area_q + 1'b1) : area_q;
		twice_sat = (area_abs[AREA_W-1:TWICE_W] != '0) ? {TWICE_W{1'b1}}
			: area_abs[TWICE_W-1:0];
		quo_x = neg_x_q ? (~dq_x_q + 1'b1) : dq_x_q;
		quo_y = neg_y_q ? (~dq_y_q + 1'b1) : dq_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			open_mode_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s1 <= sq_x;
		sq_y_s1 <= sq_y;
		pa_s1   <= a_x_q * b_y_q;
		pb_s1   <= a_y_q * b_x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q.twice_area     <= (count_q >= COUNT_W'(3)) ? twice_sat : '0;
			out_q.path_length_q8 <= (open_mode_q ? (count_q >= COUNT_W'(2))
				: (count_q >= COUNT_W'(3))) ? len_q : '0;
			out_q.box_min_x      <= min_x_q;
			out_q.box_max_x      <= max_x_q;
			out_q.box_min_y      <= min_y_q;
			out_q.box_max_y      <= max_y_q;
			out_q.centroid_x     <= quo_x[COORD_W-1:0];
			out_q.centroid_y     <= quo_y[COORD_W-1:0];
			out_q.point_count    <= count_q;
			out_q.overflow       <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			a_x_q     <= '0;
			a_y_q     <= '0;
			b_x_q     <= '0;
			b_y_q     <= '0;
			min_x_q   <= '0;
			max_x_q   <= '0;
			min_y_q   <= '0;
			max_y_q   <= '0;
			area_q    <= '0;
			len_q     <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			close_q   <= 1'b0;
			d2_q      <= '0;
			root_q    <= '0;
			rem_q     <= '0;
			step_q    <= '0;
			dq_x_q    <= '0;
			dq_y_q    <= '0;
			drem_x_q  <= '0;
			drem_y_q  <= '0;
			neg_x_q   <= 1'b0;
			neg_y_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= vertex.payload.last_vertex;
						if (full) begin
							ovf_q   <= 1'b1;
							state_q <= vertex.payload.last_vertex ? ST_CLOSE : ST_IDLE;
						end else begin
							sum_x_q  <= sum_x_q + SUM_W'(vx);
							sum_y_q  <= sum_y_q + SUM_W'(vy);
							count_q  <= count_q + 1'b1;
							prev_x_q <= vx;
							prev_y_q <= vy;
							if (count_q == '0) begin
								first_x_q <= vx;
								first_y_q <= vy;
								min_x_q   <= vx;
								max_x_q   <= vx;
								min_y_q   <= vy;
								max_y_q   <= vy;
								state_q   <= vertex.payload.last_vertex ? ST_CLOSE : ST_IDLE;
							end else begin
								if (vx < min_x_q) min_x_q <= vx;
								if (vx > max_x_q) max_x_q <= vx;
								if (vy < min_y_q) min_y_q <= vy;
								if (vy > max_y_q) max_y_q <= vy;
								a_x_q   <= prev_x_q;
								a_y_q   <= prev_y_q;
								b_x_q   <= vx;
								b_y_q   <= vy;
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					area_q  <= area_q + term_ext;
					d2_q    <= sq_x_s1 + sq_y_s1;
					root_q  <= '0;
					rem_q   <= '0;
					step_q  <= STEP_W'(SQRT_STEPS - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					rem_q  <= root_ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
					root_q <= {root_q[ROOT_W-2:0], root_ge};
					d2_q   <= {d2_q[D2_W-3:0], 2'b00};
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!close_q || !open_mode_q) len_q <= len_sat;
					if (close_q) state_q <= ST_DLOAD;
					else state_q <= last_q ? ST_CLOSE : ST_IDLE;
				end
				ST_CLOSE: begin
					if (count_q >= COUNT_W'(3)) begin
						a_x_q   <= prev_x_q;
						a_y_q   <= prev_y_q;
						b_x_q   <= first_x_q;
						b_y_q   <= first_y_q;
						close_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DLOAD;
					end
				end
				ST_DLOAD: begin
					neg_x_q  <= sum_x_q[SUM_W-1];
					neg_y_q  <= sum_y_q[SUM_W-1];
					dq_x_q   <= sum_x_q[SUM_W-1] ? (~sum_x_q + 1'b1) : sum_x_q;
					dq_y_q   <= sum_y_q[SUM_W-1] ? (~sum_y_q + 1'b1) : sum_y_q;
					drem_x_q <= '0;
					drem_y_q <= '0;
					step_q   <= STEP_W'(DIV_STEPS - 1);
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					drem_x_q <= dge_x ? COUNT_W'(dsh_x - {1'b0, count_q}) : dsh_x[COUNT_W-1:0];
					drem_y_q <= dge_y ? COUNT_W'(dsh_y - {1'b0, count_q}) : dsh_y[COUNT_W-1:0];
					dq_x_q   <= {dq_x_q[SUM_W-2:0], dge_x};
					dq_y_q   <= {dq_y_q[SUM_W-2:0], dge_y};
					step_q   <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						area_q  <= '0;
						len_q   <= '0;
						sum_x_q <= '0;
						sum_y_q <= '0;
						count_q <= '0;
						ovf_q   <= 1'b0;
						close_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
